>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks in the distance pipeline
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define GCD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// check that holds through reset as well
`define GCD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

>>> sv/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// types, fixed-point constants and helpers for the great-circle datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcd_pkg;

   typedef logic signed [23:0] lat_type;
   typedef logic signed [24:0] lon_type;
   typedef logic [23:0]        dist_type;
   typedef logic [23:0]        scale_type;

   // cordic x/y in Q30 with headroom for the gain
   localparam int XW = 34;
   // clamped cosine term, Q30
   localparam int CW = 32;
   // radicand and root of the square-root cells
   localparam int NW = 62;
   localparam int SQRT_STEPS = 31;

   localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
   // degrees to radians, Q40
   localparam logic [34:0] D2R = 35'((PI60 >> 20) / 180);
   // radians to degrees, Q24
   localparam logic [29:0] R2D = 30'((64'd180 << 54) / (PI60 >> 30));

   localparam logic signed [XW-1:0] GAIN = 34'sd652032875;
   localparam logic signed [XW-1:0] ONE_Q30 = 34'sd1073741824;

   localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
   localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;
   localparam logic [23:0]        DEG90_Q16 = 24'd5898240;
   localparam logic [23:0]        DEG180_U16 = 24'd11796480;

   localparam scale_type SCALE_RESET = 24'd1987250;
   localparam dist_type  DIST_MAX = 24'd11750400;

   // one numerator of the arctangent series, zero once the shift runs out
   function automatic logic [63:0] atan_term(input int i, input int k);
      logic [63:0] v;
      if (i * (2 * k + 1) < 63) begin
         v = (64'h1 << 62) >> (i * (2 * k + 1));
      end else begin
         v = 64'd0;
      end
      return v;
   endfunction

   // Q30 product rounded half up
   function automatic logic signed [XW-1:0] mul_q30(input logic signed [XW-1:0] a,
                                                    input logic signed [XW-1:0] b);
      logic signed [2*XW-1:0] p;
      p = (2 * XW)'(a) * (2 * XW)'(b);
      p = p + (2 * XW)'(64'sd536870912);
      return XW'(p >>> 30);
   endfunction

endpackage

>>> sv/gcd_req_if.sv
// ----------------------------------------------------------------------------
// gcd_req_if
// request channel: two points as latitude and longitude
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcd_req_if;
   import gcd_pkg::*;

   logic    valid;
   logic    ready;
   lat_type first_latitude;
   lon_type first_longitude;
   lat_type second_latitude;
   lon_type second_longitude;

   modport source (
      output valid, first_latitude, first_longitude, second_latitude, second_longitude,
      input  ready
   );

   modport sink (
      input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
      output ready
   );
endinterface

>>> sv/gcd_rsp_if.sv
// ----------------------------------------------------------------------------
// gcd_rsp_if
// response channel: one distance per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcd_rsp_if;
   import gcd_pkg::*;

   logic     valid;
   logic     ready;
   dist_type distance_km;

   modport source (
      output valid, distance_km,
      input  ready
   );

   modport sink (
      input  valid, distance_km,
      output ready
   );
endinterface

>>> sv/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// one registered micro-rotation of the sine/cosine cordic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_rot_cell #(
   parameter int            ZW = 19,
   parameter int            SHIFT = 0,
   parameter logic [ZW-1:0] ATAN = '0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [gcd_pkg::XW-1:0] x_i,
   input  logic signed [gcd_pkg::XW-1:0] y_i,
   input  logic signed [ZW-1:0]          z_i,
   output logic signed [gcd_pkg::XW-1:0] x_o,
   output logic signed [gcd_pkg::XW-1:0] y_o,
   output logic signed [ZW-1:0]          z_o
);
   import gcd_pkg::*;

   logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   logic signed [ZW-1:0] step;

   assign step = $signed(ATAN);

   always_comb begin
      // rotate towards zero residual angle
      if (!z_i[ZW-1]) begin
         x_in = x_i - (y_i >>> SHIFT);
         y_in = y_i + (x_i >>> SHIFT);
         z_in = z_i - step;
      end else begin
         x_in = x_i + (y_i >>> SHIFT);
         y_in = y_i - (x_i >>> SHIFT);
         z_in = z_i + step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
endmodule

>>> sv/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// one registered digit step of the integer square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_sqrt_cell #(
   parameter int K = 30
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [gcd_pkg::NW-1:0]  n_i,
   input  logic [gcd_pkg::NW-1:0]  root_i,
   output logic [gcd_pkg::NW-1:0]  n_o,
   output logic [gcd_pkg::NW-1:0]  root_o
);
   import gcd_pkg::*;

   localparam logic [NW-1:0] BIT = NW'(1) << (2 * K);

   logic [NW-1:0] trial;
   logic [NW-1:0] n_in, root_in, n_ff, root_ff;

   assign trial = root_i + BIT;

   always_comb begin
      if (n_i >= trial) begin
         n_in    = n_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         n_in    = n_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         root_ff <= root_in;
      end
   end

   assign n_o    = n_ff;
   assign root_o = root_ff;
endmodule

>>> sv/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// one registered micro-rotation of the arccosine vectoring cordic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_vec_cell #(
   parameter int            ZW = 19,
   parameter int            SHIFT = 0,
   parameter logic [ZW-1:0] ATAN = '0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [gcd_pkg::XW-1:0] x_i,
   input  logic signed [gcd_pkg::XW-1:0] y_i,
   input  logic signed [ZW-1:0]          z_i,
   output logic signed [gcd_pkg::XW-1:0] x_o,
   output logic signed [gcd_pkg::XW-1:0] y_o,
   output logic signed [ZW-1:0]          z_o
);
   import gcd_pkg::*;

   logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   logic signed [ZW-1:0] step;
   logic                 y_pos;

   assign step  = $signed(ATAN);
   assign y_pos = !y_i[XW-1] && (y_i != '0);

   always_comb begin
      // drive y towards zero, angle gathers in z
      if (y_pos) begin
         x_in = x_i + (y_i >>> SHIFT);
         y_in = y_i - (x_i >>> SHIFT);
         z_in = z_i + step;
      end else begin
         x_in = x_i - (y_i >>> SHIFT);
         y_in = y_i + (x_i >>> SHIFT);
         z_in = z_i - step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
endmodule

>>> sv/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance: law-of-cosines distance between two points
// throughput: one pair per cycle while the skid stage is empty, set by the fully unrolled cordic and root rows
// reset clears all valid flags and the skid stage, scale returns to 1987250
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module great_circle_distance #(
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int CORDIC_STAGES = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  gcd_pkg::scale_type  csr_wr_data,
   gcd_req_if.sink             req_ch,
   gcd_rsp_if.source           rsp_ch
);
   import gcd_pkg::*;

   localparam int F = ANGLE_FRAC_BITS;
   localparam int N = CORDIC_STAGES;
   localparam int ZW = F + 3;
   localparam int AW = F + 2;
   localparam int DEPTH = 9 + SQRT_STEPS + 2 * N;
   localparam logic [ZW-1:0] HALF_PI = ZW'((PI60 + (64'h1 << (60 - F))) >> (61 - F));

   typedef struct packed {
      logic [2:0] cneg;
      logic [1:0] sneg;
   } flags_type;

   logic en;
   logic [DEPTH-1:0] v_ff;
   scale_type scale_ff;

   // front: reduce, fold, convert to radians
   lat_type          lat1_p0_ff, lat2_p0_ff;
   logic signed [25:0] dlon_in, dlon_p0_ff, dlon_red;
   logic signed [24:0] ang_p1_in [0:2];
   logic signed [24:0] ang_p1_ff [0:2];
   logic [22:0]        mag_p2_in [0:2];
   logic [22:0]        mag_p2_ff [0:2];
   flags_type          flags_p2_in, flags_p2_ff, flags_p3_ff;
   logic signed [ZW-1:0] z_p3_in [0:2];
   logic signed [ZW-1:0] z_p3_ff [0:2];
   flags_type          flag_ff [0:N-1];

   logic signed [XW-1:0] rot_x [0:N][0:2];
   logic signed [XW-1:0] rot_y [0:N][0:2];
   logic signed [ZW-1:0] rot_z [0:N][0:2];

   // cosine term
   logic signed [XW-1:0] s1, s2, c1, c2, cd;
   logic signed [XW-1:0] ss_in, cc_in, ss_m1_ff, cc_m1_ff, cd_m1_ff;
   logic signed [XW-1:0] q_in, q_m2_ff, ss_m2_ff;
   logic signed [XW:0]   csum;
   logic signed [CW-1:0] c_in, c_ff;
   logic signed [63:0]   c_sq;
   logic [NW-1:0]        n_in, n_ff;
   logic signed [CW-1:0] c_sq_ff;
   logic signed [CW-1:0] c_line_ff [0:SQRT_STEPS-1];

   logic [NW-1:0] sq_n [0:SQRT_STEPS];
   logic [NW-1:0] sq_r [0:SQRT_STEPS];

   logic signed [XW-1:0] vec_x [0:N];
   logic signed [XW-1:0] vec_y [0:N];
   logic signed [ZW-1:0] vec_z [0:N];

   logic [AW-1:0]   ang;
   logic [F+31:0]   deg_prod;
   logic [23:0]     deg_in, deg_ff;
   logic [48:0]     km_prod;
   logic [24:0]     km_wide;
   dist_type        km_in;

   logic     out_valid_ff, skid_valid_ff;
   dist_type out_data_ff, skid_data_ff;
   logic     leaving;

   assign en = ~skid_valid_ff;
   assign req_ch.ready = en;

   // ---------------- config ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // ---------------- valid line ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DEPTH-2:0], req_ch.valid};
      end
   end

   // ---------------- front stages ----------------
   assign dlon_in = 26'(req_ch.second_longitude) - 26'(req_ch.first_longitude);

   always_comb begin
      // longitude difference lies within two turns, one correction is enough
      if (dlon_p0_ff > DEG180_Q16) begin
         dlon_red = dlon_p0_ff - DEG360_Q16;
      end else if (dlon_p0_ff < -DEG180_Q16) begin
         dlon_red = dlon_p0_ff + DEG360_Q16;
      end else begin
         dlon_red = dlon_p0_ff;
      end
      ang_p1_in[0] = 25'(lat1_p0_ff);
      ang_p1_in[1] = 25'(lat2_p0_ff);
      ang_p1_in[2] = 25'(dlon_red);
   end

   always_comb begin
      logic [23:0] mag;
      flags_p2_in = '0;
      for (int l = 0; l < 3; l++) begin
         mag = ang_p1_ff[l][24] ? 24'(-ang_p1_ff[l]) : 24'(ang_p1_ff[l]);
         if (l < 2) begin
            flags_p2_in.sneg[l] = ang_p1_ff[l][24];
         end
         // fold into the first quadrant, cosine changes sign
         if (mag > DEG90_Q16) begin
            mag_p2_in[l] = 23'(DEG180_U16 - mag);
            flags_p2_in.cneg[l] = 1'b1;
         end else begin
            mag_p2_in[l] = 23'(mag);
         end
      end
   end

   always_comb begin
      logic [58:0] prod;
      for (int l = 0; l < 3; l++) begin
         prod = 59'(mag_p2_ff[l]) * 59'(D2R) + (59'(1) << (55 - F));
         z_p3_in[l] = ZW'(prod >> (56 - F));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat1_p0_ff  <= req_ch.first_latitude;
         lat2_p0_ff  <= req_ch.second_latitude;
         dlon_p0_ff  <= dlon_in;
         ang_p1_ff   <= ang_p1_in;
         mag_p2_ff   <= mag_p2_in;
         flags_p2_ff <= flags_p2_in;
         z_p3_ff     <= z_p3_in;
         flags_p3_ff <= flags_p2_ff;
         flag_ff[0]  <= flags_p3_ff;
         for (int j = 1; j < N; j++) begin
            flag_ff[j] <= flag_ff[j-1];
         end
      end
   end

   // ---------------- cordic rows ----------------
   for (genvar l = 0; l < 3; l++) begin : g_rot_seed
      assign rot_x[0][l] = GAIN;
      assign rot_y[0][l] = '0;
      assign rot_z[0][l] = z_p3_ff[l];
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam logic [63:0] ATAN_Q62 = (s == 0) ? PI60 :
         atan_term(s, 0) / 64'd1 - atan_term(s, 1) / 64'd3 +
         atan_term(s, 2) / 64'd5 - atan_term(s, 3) / 64'd7 +
         atan_term(s, 4) / 64'd9 - atan_term(s, 5) / 64'd11 +
         atan_term(s, 6) / 64'd13 - atan_term(s, 7) / 64'd15 +
         atan_term(s, 8) / 64'd17 - atan_term(s, 9) / 64'd19 +
         atan_term(s, 10) / 64'd21 - atan_term(s, 11) / 64'd23 +
         atan_term(s, 12) / 64'd25 - atan_term(s, 13) / 64'd27 +
         atan_term(s, 14) / 64'd29 - atan_term(s, 15) / 64'd31 +
         atan_term(s, 16) / 64'd33 - atan_term(s, 17) / 64'd35 +
         atan_term(s, 18) / 64'd37 - atan_term(s, 19) / 64'd39 +
         atan_term(s, 20) / 64'd41 - atan_term(s, 21) / 64'd43 +
         atan_term(s, 22) / 64'd45 - atan_term(s, 23) / 64'd47 +
         atan_term(s, 24) / 64'd49 - atan_term(s, 25) / 64'd51 +
         atan_term(s, 26) / 64'd53 - atan_term(s, 27) / 64'd55 +
         atan_term(s, 28) / 64'd57 - atan_term(s, 29) / 64'd59 +
         atan_term(s, 30) / 64'd61;
      localparam logic [ZW-1:0] ATAN =
         ZW'((ATAN_Q62 + (64'h1 << (61 - F))) >> (62 - F));

      for (genvar l = 0; l < 3; l++) begin : g_lane
         gcd_rot_cell #(
            .ZW    (ZW),
            .SHIFT (s),
            .ATAN  (ATAN)
         ) u_rot (
            .clock (clock),
            .en    (en),
            .x_i   (rot_x[s][l]),
            .y_i   (rot_y[s][l]),
            .z_i   (rot_z[s][l]),
            .x_o   (rot_x[s+1][l]),
            .y_o   (rot_y[s+1][l]),
            .z_o   (rot_z[s+1][l])
         );
      end

      gcd_vec_cell #(
         .ZW    (ZW),
         .SHIFT (s),
         .ATAN  (ATAN)
      ) u_vec (
         .clock (clock),
         .en    (en),
         .x_i   (vec_x[s]),
         .y_i   (vec_y[s]),
         .z_i   (vec_z[s]),
         .x_o   (vec_x[s+1]),
         .y_o   (vec_y[s+1]),
         .z_o   (vec_z[s+1])
      );
   end

   // ---------------- cosine term and clamp ----------------
   assign s1 = flag_ff[N-1].sneg[0] ? -rot_y[N][0] : rot_y[N][0];
   assign s2 = flag_ff[N-1].sneg[1] ? -rot_y[N][1] : rot_y[N][1];
   assign c1 = flag_ff[N-1].cneg[0] ? -rot_x[N][0] : rot_x[N][0];
   assign c2 = flag_ff[N-1].cneg[1] ? -rot_x[N][1] : rot_x[N][1];
   assign cd = flag_ff[N-1].cneg[2] ? -rot_x[N][2] : rot_x[N][2];

   assign ss_in = mul_q30(s1, s2);
   assign cc_in = mul_q30(c1, c2);
   assign q_in  = mul_q30(cc_m1_ff, cd_m1_ff);

   always_comb begin
      csum = (XW + 1)'(ss_m2_ff) + (XW + 1)'(q_m2_ff);
      if (csum > (XW + 1)'(ONE_Q30)) begin
         c_in = CW'(ONE_Q30);
      end else if (csum < -((XW + 1)'(ONE_Q30))) begin
         c_in = CW'(-ONE_Q30);
      end else begin
         c_in = CW'(csum);
      end
   end

   assign c_sq = 64'(c_ff) * 64'(c_ff);
   assign n_in = NW'((64'sd1 <<< 60) - c_sq);

   always_ff @(posedge clock) begin
      if (en) begin
         ss_m1_ff <= ss_in;
         cc_m1_ff <= cc_in;
         cd_m1_ff <= cd;
         q_m2_ff  <= q_in;
         ss_m2_ff <= ss_m1_ff;
         c_ff     <= c_in;
         n_ff     <= n_in;
         c_sq_ff  <= c_ff;
         c_line_ff[0] <= c_sq_ff;
         for (int j = 1; j < SQRT_STEPS; j++) begin
            c_line_ff[j] <= c_line_ff[j-1];
         end
      end
   end

   // ---------------- square-root row ----------------
   assign sq_n[0] = n_ff;
   assign sq_r[0] = '0;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      gcd_sqrt_cell #(
         .K (SQRT_STEPS - 1 - j)
      ) u_sqrt (
         .clock  (clock),
         .en     (en),
         .n_i    (sq_n[j]),
         .root_i (sq_r[j]),
         .n_o    (sq_n[j+1]),
         .root_o (sq_r[j+1])
      );
   end

   // vector seed: obtuse angles start a quarter turn on
   always_comb begin
      if (c_line_ff[SQRT_STEPS-1][CW-1]) begin
         vec_x[0] = XW'(sq_r[SQRT_STEPS]);
         vec_y[0] = -(XW'(c_line_ff[SQRT_STEPS-1]));
         vec_z[0] = $signed(HALF_PI);
      end else begin
         vec_x[0] = XW'(c_line_ff[SQRT_STEPS-1]);
         vec_y[0] = XW'(sq_r[SQRT_STEPS]);
         vec_z[0] = '0;
      end
   end

   // ---------------- degrees and distance ----------------
   assign ang      = vec_z[N][ZW-1] ? '0 : vec_z[N][AW-1:0];
   assign deg_prod = (F + 32)'(ang) * (F + 32)'(R2D) + ((F + 32)'(1) << (F + 7));
   assign deg_in   = deg_prod[F+31:F+8];

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff <= deg_in;
      end
   end

   assign km_prod = 49'(deg_ff) * 49'(scale_ff) + (49'(1) << 23);
   assign km_wide = km_prod[48:24];
   assign km_in   = (km_wide > 25'(DIST_MAX)) ? DIST_MAX : km_wide[23:0];

   // ---------------- output register and skid ----------------
   assign leaving = en & v_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (leaving) begin
         if (out_valid_ff && !rsp_ch.ready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (leaving) begin
         if (out_valid_ff && !rsp_ch.ready) begin
            skid_data_ff <= km_in;
         end else begin
            out_data_ff <= km_in;
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.distance_km = out_data_ff;

   // ---------------- checks ----------------
   `GCD_ASSERT_ALWAYS(a_skid_behind_out, clock, skid_valid_ff |-> out_valid_ff)
   `GCD_ASSERT(a_beat_enters, clock, reset, (req_ch.valid && req_ch.ready) |=> v_ff[0])
   `GCD_ASSERT(a_frozen_hold, clock, reset, !req_ch.ready |=> $stable(v_ff))
   `GCD_ASSERT(a_skid_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ch.ready))
   `GCD_ASSERT(a_saturated, clock, reset, out_valid_ff |-> (out_data_ff <= DIST_MAX))

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for great_circle_distance: directed and random point
// pairs are sent in bursts against a stalling receiver, and every distance is
// compared with a bit-exact fixed-point model of the law-of-cosines datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import gcd_pkg::*;

   typedef struct {
      lat_type first_latitude;
      lon_type first_longitude;
      lat_type second_latitude;
      lon_type second_longitude;
   } point_pair_t;

   localparam int STAGES = 24;
   localparam int FRAC = 16;
   localparam int PIPE_LATENCY = 2 * STAGES + 41;
   localparam int CYCLE_LIMIT = 300000;
   localparam longint LAT_MAX = 5898240;
   localparam longint LON_MAX = 11796480;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   scale_type csr_wr_data;

   gcd_req_if req_if ();
   gcd_rsp_if rsp_if ();

   great_circle_distance dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   point_pair_t pending_pairs[$];
   dist_type    expected_distances[$];
   point_pair_t pair_on_bus;
   scale_type   km_scale;
   longint      atan_lut[STAGES];
   int          error_count;
   int          cycle_count;
   int          burst_left;
   int          gap_left;
   int          stall_pct;

   // ---------------------------------------------------------------- model

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic void fill_atan_lut();
      longint acc;
      longint term;
      longint unsigned v;
      for (int i = 0; i < STAGES; i++) begin
         if (i == 0) begin
            v = PI60;
         end else begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) < 63; k++) begin
               term = longint'(((64'h1 << 62) >> (i * (2 * k + 1))) / (2 * k + 1));
               acc = (k % 2 == 1) ? acc - term : acc + term;
            end
            v = longint'(acc);
         end
         atan_lut[i] = longint'((v + (64'h1 << (61 - FRAC))) >> (62 - FRAC));
      end
   endfunction

   function automatic void rotate_sin_cos(longint deg, output longint s_val,
                                          output longint c_val);
      longint r, m, z, x, y, dx, dy;
      longint unsigned d2r;
      bit sneg, cneg;
      r = deg % (360 * 65536);
      if (r > 180 * 65536) r = r - 360 * 65536;
      if (r < -180 * 65536) r = r + 360 * 65536;
      sneg = r < 0;
      m = sneg ? -r : r;
      cneg = 0;
      if (m > 90 * 65536) begin
         m = 180 * 65536 - m;
         cneg = 1;
      end
      d2r = (PI60 >> 20) / 180;
      z = longint'((longint'(m) * d2r + (64'h1 << (55 - FRAC))) >> (56 - FRAC));
      x = 652032875;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_lut[i];
         end else begin
            x += dx; y -= dy; z += atan_lut[i];
         end
      end
      s_val = sneg ? -y : y;
      c_val = cneg ? -x : x;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint central_angle(longint c);
      longint x, y, z, dx, dy, tmp;
      x = c;
      y = longint'(int_sqrt(longint'((64'sd1 <<< 60) - c * c)));
      z = 0;
      if (x < 0) begin
         tmp = x;
         x = y;
         y = -tmp;
         z = longint'((PI60 + (64'h1 << (60 - FRAC))) >> (61 - FRAC));
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += atan_lut[i];
         end else begin
            x -= dx; y += dy; z -= atan_lut[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic dist_type predict_distance(point_pair_t p, scale_type scale);
      longint s1, c1, s2, c2, sd, cd, c, ang;
      longint unsigned r2d, deg16, km;
      rotate_sin_cos(longint'(p.first_latitude), s1, c1);
      rotate_sin_cos(longint'(p.second_latitude), s2, c2);
      rotate_sin_cos(longint'(p.second_longitude) - longint'(p.first_longitude), sd, cd);
      c = round_q30(s1, s2) + round_q30(round_q30(c1, c2), cd);
      if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
      if (c < -(64'sd1 <<< 30)) c = -(64'sd1 <<< 30);
      ang = central_angle(c);
      r2d = (64'd180 << 54) / (PI60 >> 30);
      deg16 = (longint'(ang) * r2d + (64'h1 << (FRAC + 7))) >> (FRAC + 8);
      km = (deg16 * longint'(scale) + (64'h1 << 23)) >> 24;
      if (km > 11750400) km = 11750400;
      return dist_type'(km);
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic longint deg_q16(int whole);
      return longint'(whole) * 65536;
   endfunction

   task automatic add_pair(longint la1, longint lo1, longint la2, longint lo2);
      point_pair_t p;
      p.first_latitude = lat_type'(la1);
      p.first_longitude = lon_type'(lo1);
      p.second_latitude = lat_type'(la2);
      p.second_longitude = lon_type'(lo2);
      pending_pairs.push_back(p);
   endtask

   function automatic longint pick_lat();
      if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom)));
      return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic longint pick_lon();
      if ($urandom_range(0, 9) == 0) return longint'($signed(25'($urandom)));
      return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
   endfunction

   task automatic add_random_pairs(int count);
      longint la, lo;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            // nearby or near-antipodal partner
            la = pick_lat();
            lo = pick_lon();
            if ($urandom_range(0, 1) == 1)
               add_pair(la, lo, la + $urandom_range(0, 200) - 100,
                        lo + $urandom_range(0, 200) - 100);
            else
               add_pair(la, lo, -la + $urandom_range(0, 20) - 10,
                        lo + deg_q16(180) + $urandom_range(0, 20) - 10);
         end else begin
            add_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() != 0 || req_if.valid || expected_distances.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_scale(scale_type value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      km_scale = value;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------- sequence

   initial begin
      fill_atan_lut();
      km_scale = SCALE_RESET;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zeros, same point, poles, antipodes, wrapped longitudes, extremes
      add_pair(0, 0, 0, 0);
      add_pair(deg_q16(45), deg_q16(10), deg_q16(45), deg_q16(10));
      add_pair(LAT_MAX, 0, -LAT_MAX, 0);
      add_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
      add_pair(0, 0, 0, LON_MAX);
      add_pair(0, -LON_MAX, 0, LON_MAX);
      add_pair(0, -LON_MAX, 0, LON_MAX - 1);
      add_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
      add_pair(0, 0, 1, 1);
      add_pair(deg_q16(30), deg_q16(-100), deg_q16(-30), deg_q16(80));
      add_pair(-(64'sd1 <<< 23), -(64'sd1 <<< 24), (64'sd1 <<< 23) - 1, (64'sd1 <<< 24) - 1);
      add_pair((64'sd1 <<< 23) - 1, (64'sd1 <<< 24) - 1, -(64'sd1 <<< 23), -(64'sd1 <<< 24));
      add_pair(deg_q16(100), deg_q16(170), deg_q16(-120), deg_q16(-170));
      add_pair(deg_q16(51), 0, deg_q16(40), deg_q16(-74));
      add_pair(0, 0, 0, deg_q16(90));
      add_pair(deg_q16(90), deg_q16(33), deg_q16(90), deg_q16(-140));
      wait_idle();

      // saturation and zero scale
      write_scale(24'hFFFFFF);
      add_pair(LAT_MAX, 0, -LAT_MAX, 0);
      add_pair(0, 0, 0, deg_q16(60));
      add_pair(0, 0, 0, deg_q16(1));
      add_random_pairs(40);
      wait_idle();
      write_scale(24'd0);
      add_pair(LAT_MAX, 0, -LAT_MAX, 0);
      add_random_pairs(20);
      wait_idle();
      write_scale(24'd65536);
      add_random_pairs(150);
      wait_idle();
      write_scale(24'd16711680);
      add_random_pairs(150);
      wait_idle();
      write_scale(scale_type'($urandom_range(65536, 16711680)));
      add_random_pairs(150);
      wait_idle();
      write_scale(SCALE_RESET);
      add_random_pairs(300);
      wait_idle();

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // ------------------------------------------------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.first_latitude <= '0;
         req_if.first_longitude <= '0;
         req_if.second_latitude <= '0;
         req_if.second_longitude <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_distances.push_back(predict_distance(pair_on_bus, km_scale));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               pair_on_bus = pending_pairs.pop_front();
               req_if.valid <= 1'b1;
               req_if.first_latitude <= pair_on_bus.first_latitude;
               req_if.first_longitude <= pair_on_bus.first_longitude;
               req_if.second_latitude <= pair_on_bus.second_latitude;
               req_if.second_longitude <= pair_on_bus.second_longitude;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(0, 40);
                  // no gap at all every so often
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------ response monitor

   always @(posedge clock) begin
      dist_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_pct <= 0;
         cycle_count <= 0;
         error_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count % 97 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct <= 0;
               1: stall_pct <= 25;
               2: stall_pct <= 60;
               default: stall_pct <= 90;
            endcase
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected distance beat, expected none, actual %0d",
                        $time, rsp_if.distance_km);
               error_count <= error_count + 1;
            end else begin
               want = expected_distances.pop_front();
               if (rsp_if.distance_km !== want) begin
                  $display("%0t: distance_km mismatch, expected %0d, actual %0d",
                           $time, want, rsp_if.distance_km);
                  error_count <= error_count + 1;
               end
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule

>>> filelist.f
+incdir+sv
sv/gcd_pkg.sv
sv/gcd_req_if.sv
sv/gcd_rsp_if.sv
sv/gcd_rot_cell.sv
sv/gcd_sqrt_cell.sv
sv/gcd_vec_cell.sv
sv/great_circle_distance.sv
tb/sv/tb.sv
